// ===== rtl/dthc_pkg.sv =====
package dthc_pkg;

    // Field and port widths.
    localparam int LEVEL_W     = 18;
    localparam int LEVEL_TDATA = 24;
    localparam int RANGE_W     = 10;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int PIXEL_W     = CHAN_W * NUM_CHAN;

    // Fixed-point position: 10 fractional bits, index in the bits above.
    localparam int FRAC_BITS   = 10;
    localparam int POS_W       = 15;
    localparam int IDX_W       = POS_W - FRAC_BITS;
    localparam int PROD_NUM_W  = 24;
    localparam int PAL_LEN     = 19;

    // Divider layout: the quotient bits are spread over the divider stages.
    localparam int DIV_STEPS   = 3;
    localparam int DIV_STAGES  = POS_W / DIV_STEPS;

    localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(180);

    // One pixel, red in the lowest byte.
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

    // Item as it travels through the divider stages.
    typedef struct packed {
        logic [RANGE_W-1:0] rem;
        logic [POS_W-1:0]   num;
        logic [POS_W-1:0]   quo;
        logic               white;
        logic               black;
    } div_t;

    // Heat palette, from white at 0 dB down to black at the floor.
    function automatic rgb_t pal_rgb(input logic [IDX_W-1:0] idx);
        rgb_t c;
        unique case (idx)
            5'd0:    c = {8'd255, 8'd255, 8'd255};
            5'd1:    c = {8'd216, 8'd254, 8'd240};
            5'd2:    c = {8'd185, 8'd251, 8'd242};
            5'd3:    c = {8'd143, 8'd245, 8'd253};
            5'd4:    c = {8'd102, 8'd200, 8'd253};
            5'd5:    c = {8'd66,  8'd144, 8'd252};
            5'd6:    c = {8'd32,  8'd75,  8'd252};
            5'd7:    c = {8'd41,  8'd28,  8'd237};
            5'd8:    c = {8'd64,  8'd3,   8'd214};
            5'd9:    c = {8'd101, 8'd3,   8'd183};
            5'd10:   c = {8'd122, 8'd3,   8'd157};
            5'd11:   c = {8'd126, 8'd3,   8'd122};
            5'd12:   c = {8'd110, 8'd2,   8'd80};
            5'd13:   c = {8'd89,  8'd2,   8'd45};
            5'd14:   c = {8'd70,  8'd2,   8'd19};
            5'd15:   c = {8'd53,  8'd3,   8'd1};
            5'd16:   c = {8'd37,  8'd3,   8'd1};
            5'd17:   c = {8'd19,  8'd2,   8'd1};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/dthc_div_stage.sv =====
// One stage of the restoring divider: brings in DIV_STEPS numerator bits,
// produces as many quotient bits, and registers the partial result.
module dthc_div_stage (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [dthc_pkg::RANGE_W-1:0] rng,
    input  dthc_pkg::div_t            d_in,
    output dthc_pkg::div_t            d_out
);
    import dthc_pkg::*;

    div_t             d_reg;
    div_t             d_next;
    logic [RANGE_W:0] trial;

    // Shift-compare-subtract, one quotient bit per step.
    always_comb begin
        d_next = d_in;
        trial  = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial      = {d_next.rem, d_next.num[POS_W-1]};
            d_next.num = {d_next.num[POS_W-2:0], 1'b0};
            if (trial >= {1'b0, rng}) begin
                d_next.rem = RANGE_W'(trial - {1'b0, rng});
                d_next.quo = {d_next.quo[POS_W-2:0], 1'b1};
            end else begin
                d_next.rem = trial[RANGE_W-1:0];
                d_next.quo = {d_next.quo[POS_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== rtl/db_to_heat_colour_map_unit.sv =====
// Channel  | Ports                          | Payload (lowest bit first)
// ---------+--------------------------------+--------------------------------
// input    | s_tvalid, s_tready, s_tdata    | level_db[17:0], zeros[23:18]
// result   | m_tvalid, m_tready, m_tdata    | red[7:0], green[15:8], blue[23:16]
// config   | cfg_wr_en, cfg_wr_data         | dynamic_range_db[9:0]
//
// One item per clock while the result side keeps taking items; a stalled output holds the flow.
// The pipeline holds the five divider stages, three quotient bits each,
// plus magnitude, scaling, palette, multiply and output stages.
// Reset (synchronous, active low) empties the pipeline and loads a range of 180.
// A stalled output holds only the stages behind it that are full; empty stages
// keep taking items, so bubbles are squeezed out before the input stalls.
module db_to_heat_colour_map_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // level_db[17:0], zero padding [23:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // red[7:0], green[15:8], blue[23:16]
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data
);
    import dthc_pkg::*;

    localparam int NSTG    = DIV_STAGES + 5;
    localparam int ST_DIV  = 2;
    localparam int ST_PAL  = ST_DIV + DIV_STAGES;
    localparam int ST_MUL  = ST_PAL + 1;
    localparam int ST_OUT  = ST_MUL + 1;

    // Range register and the values derived from it.
    logic [RANGE_W-1:0] range_reg;
    logic [RANGE_W-1:0] rng;
    logic [POS_W-1:0]   rng18;

    // Pipeline control.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    // Stage payloads.
    logic               neg_reg;
    logic [LEVEL_W-1:0] mag_reg;
    logic [PROD_NUM_W-1:0] prod_num;
    div_t               div_in_reg;
    div_t               div_bus [DIV_STAGES+1];
    rgb_t               pa_reg;
    rgb_t               pb_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [NUM_CHAN-1:0][CHAN_W+FRAC_BITS:0] wa_reg;
    logic [NUM_CHAN-1:0][CHAN_W+FRAC_BITS-1:0] wb_reg;
    rgb_t               out_reg;
    rgb_t               out_next;
    rgb_t               pa_next;
    rgb_t               pb_next;
    logic [FRAC_BITS-1:0] frac_next;
    logic [LEVEL_W-1:0] level;
    logic [CHAN_W+FRAC_BITS:0] blend_sum [NUM_CHAN];

    // Configuration write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= RANGE_RESET;
        end else if (cfg_wr_en) begin
            range_reg <= cfg_wr_data;
        end
    end

    // A range of zero behaves as one; 18 * range marks the black limit.
    assign rng   = (range_reg == '0) ? RANGE_W'(1) : range_reg;
    assign rng18 = POS_W'({rng, 4'b0}) + POS_W'({rng, 1'b0});

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];

    // Valid bits travel with the items.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 0: sign and magnitude of the level.
    assign level = s_tdata[LEVEL_W-1:0];

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            neg_reg <= level[LEVEL_W-1];
            mag_reg <= LEVEL_W'(~level + LEVEL_W'(1));
        end
    end

    // Stage 1: scale by 72 and decide black before dividing.
    assign prod_num = PROD_NUM_W'({mag_reg, 6'b0}) + PROD_NUM_W'({mag_reg, 3'b0});

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            div_in_reg.rem   <= RANGE_W'(prod_num[PROD_NUM_W-1:POS_W]);
            div_in_reg.num   <= prod_num[POS_W-1:0];
            div_in_reg.quo   <= '0;
            div_in_reg.white <= !neg_reg;
            div_in_reg.black <= ({1'b0, prod_num[PROD_NUM_W-1:FRAC_BITS]} >= rng18);
        end
    end

    // Divider stages.
    assign div_bus[0] = div_in_reg;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        dthc_div_stage u_div (
            .aclk  (aclk),
            .en    (adv[ST_DIV+g]),
            .rng   (rng),
            .d_in  (div_bus[g]),
            .d_out (div_bus[g+1])
        );
    end

    // Palette stage: pick the two entries around the position.
    always_comb begin
        if (div_bus[DIV_STAGES].white) begin
            pa_next   = pal_rgb('0);
            pb_next   = pal_rgb('0);
            frac_next = '0;
        end else if (div_bus[DIV_STAGES].black) begin
            pa_next   = pal_rgb(IDX_W'(PAL_LEN - 1));
            pb_next   = pal_rgb(IDX_W'(PAL_LEN - 1));
            frac_next = '0;
        end else begin
            pa_next   = pal_rgb(div_bus[DIV_STAGES].quo[POS_W-1:FRAC_BITS]);
            pb_next   = pal_rgb(IDX_W'(div_bus[DIV_STAGES].quo[POS_W-1:FRAC_BITS] + 1'b1));
            frac_next = div_bus[DIV_STAGES].quo[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_PAL]) begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            frac_reg <= frac_next;
        end
    end

    // Multiply stage: weight both entries of each channel.
    always_ff @(posedge aclk) begin
        if (adv[ST_MUL]) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                wa_reg[c] <= (CHAN_W+FRAC_BITS+1)'(pa_reg[c])
                           * (CHAN_W+FRAC_BITS+1)'((FRAC_BITS+1)'(1 << FRAC_BITS)
                                                   - {1'b0, frac_reg});
                wb_reg[c] <= (CHAN_W+FRAC_BITS)'(pb_reg[c])
                           * (CHAN_W+FRAC_BITS)'(frac_reg);
            end
        end
    end

    // Output stage: sum, round to nearest with halves up.
    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            blend_sum[c] = wa_reg[c] + {1'b0, wb_reg[c]}
                         + (CHAN_W+FRAC_BITS+1)'(1 << (FRAC_BITS - 1));
            out_next[c]  = blend_sum[c][FRAC_BITS +: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_OUT]) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vld_reg[ST_OUT];
    assign m_tdata  = out_reg;

endmodule

// ===== rtl/dthc_checker.sv =====
// Port-level checks for the heat colour map.
module dthc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // A result that is not taken keeps its pixel.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    // An empty output stage means no stage can be blocked.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item offered right after reset");

endmodule

bind db_to_heat_colour_map_unit dthc_checker u_dthc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/heat_pixel_checker.sv =====
module heat_pixel_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [dthc_pkg::LEVEL_TDATA-1:0] s_tdata,     // level_db[17:0], zero padding [23:18]
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [dthc_pkg::PIXEL_W-1:0]     m_tdata,     // red[7:0], green[15:8], blue[23:16]
    input  logic                             cfg_wr_en,
    input  logic [dthc_pkg::RANGE_W-1:0]     cfg_wr_data,
    output int                               mismatch_count,
    output int                               pixels_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import dthc_pkg::*;

    // Heat palette by channel, white at index 0 down to black at the floor.
    int unsigned pal_r [PAL_LEN] = '{255, 240, 242, 253, 253, 252, 252, 237, 214, 183,
                                     157, 122,  80,  45,  19,   1,   1,   1,   0};
    int unsigned pal_g [PAL_LEN] = '{255, 254, 251, 245, 200, 144,  75,  28,   3,   3,
                                       3,   3,   2,   2,   2,   3,   3,   2,   0};
    int unsigned pal_b [PAL_LEN] = '{255, 216, 185, 143, 102,  66,  32,  41,  64, 101,
                                     122, 126, 110,  89,  70,  53,  37,  19,   0};

    string chan_name [NUM_CHAN] = '{"red", "green", "blue"};

    logic [RANGE_W-1:0] span_db = RANGE_RESET;
    rgb_t               due_pixels [$];

    // Linear blend of two palette entries, rounded to nearest with halves up.
    function automatic logic [CHAN_W-1:0] blend(input int unsigned a, input int unsigned b,
                                                input int unsigned frac);
        return CHAN_W'((a * (1024 - frac) + b * frac + 512) >> FRAC_BITS);
    endfunction

    // Expected pixel for one level under the given dynamic range.
    function automatic rgb_t heat_pixel(input logic [LEVEL_W-1:0] lvl,
                                        input logic [RANGE_W-1:0] span);
        rgb_t        px;
        int unsigned mag;
        int unsigned divisor;
        int unsigned pos;
        int unsigned idx;
        int unsigned frac;
        if (!lvl[LEVEL_W-1]) begin
            px = {NUM_CHAN{8'd255}};
            return px;
        end
        // The level is negative here, so the magnitude is 2^18 minus the raw bits;
        // the most negative level gives 131072.
        mag = (1 << LEVEL_W) - int'(lvl);
        divisor = (span == '0) ? 1 : int'(span);
        pos = (mag * 72) / divisor;
        idx = pos >> FRAC_BITS;
        frac = pos & ((1 << FRAC_BITS) - 1);
        if (idx >= PAL_LEN - 1) begin
            px = '0;
        end else begin
            px[0] = blend(pal_r[idx], pal_r[idx + 1], frac);
            px[1] = blend(pal_g[idx], pal_g[idx + 1], frac);
            px[2] = blend(pal_b[idx], pal_b[idx + 1], frac);
        end
        return px;
    endfunction

    // Track the register, predict each accepted item and compare each result.
    always @(posedge aclk) begin
        rgb_t want;
        rgb_t got;
        string diffs;
        if (!aresetn) begin
            span_db = RANGE_RESET;
            due_pixels.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_wr_en) begin
                span_db = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                due_pixels.push_back(heat_pixel(s_tdata[LEVEL_W-1:0], span_db));
            end
            if (m_tvalid && m_tready) begin
                got = rgb_t'(m_tdata);
                if (due_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: pixel r=%0d g=%0d b=%0d with no item pending", $time,
                                 got[0], got[1], got[2]);
                    end
                end else begin
                    want = due_pixels.pop_front();
                    diffs = "";
                    for (int c = 0; c < NUM_CHAN; c++) begin
                        if (got[c] !== want[c]) begin
                            diffs = {diffs, $sformatf(" %s exp %0d got %0d", chan_name[c],
                                                      want[c], got[c])};
                        end
                    end
                    if (diffs != "") begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: pixel mismatch:%s", $time, diffs);
                        end
                    end
                end
            end
        end
        pixels_due = due_pixels.size();
    end

endmodule

// ===== verif/tb_db_to_heat_colour_map_unit.sv =====
module tb_db_to_heat_colour_map_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import dthc_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [LEVEL_TDATA-1:0] s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [PIXEL_W-1:0]     m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [RANGE_W-1:0]     cfg_wr_data = '0;

    int mismatch_count;
    int pixels_due;

    bit src_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    int stall_left = 0;
    int roll;

    db_to_heat_colour_map_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    heat_pixel_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .pixels_due     (pixels_due)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("db_to_heat_colour_map_unit verification failed");
        $finish;
    end

    // Result side back-pressure: mostly short stalls, now and then a long one.
    always @(posedge aclk) begin
        if (!sink_stalls) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else if (roll < 23) begin
                stall_left = $urandom_range(8, 40);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Offer one level and hold it until the block takes it.
    task automatic send_level(input int lvl);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(LEVEL_TDATA - LEVEL_W){1'b0}}, lvl[LEVEL_W-1:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Random level shaped around the current range: mostly on the palette,
    // some near palette steps, some at or above 0 dB, some anywhere.
    function automatic int random_level(input int unsigned span);
        int unsigned eff;
        int unsigned top;
        int unsigned mag;
        int unsigned k;
        int unsigned r;
        eff = (span == 0) ? 1 : span;
        top = eff * 256 * 19 / 18 + 16;
        if (top > 131072) top = 131072;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return int'($urandom_range(0, 262143));
        end else if (r <= 2) begin
            return int'($urandom_range(0, 131071));
        end else if (r <= 4) begin
            k = $urandom_range(1, 18);
            mag = (k * 1024 * eff + 71) / 72 + $urandom_range(0, 2);
            mag = (mag > 1) ? mag - 1 : 1;
            if (mag > 131072) mag = 131072;
            return -int'(mag);
        end
        mag = $urandom_range(1, top);
        return -int'(mag);
    endfunction

    // Let the pipeline drain before touching the register. The first edge
    // makes sure the count already holds the last accepted item.
    task automatic settle();
        @(posedge aclk);
        while (pixels_due != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_span(input int unsigned span);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= span[RANGE_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int unsigned spans [8];
        int unsigned span_now;
        spans = '{RANGE_RESET, 1, 1023, 0, 60, $urandom_range(2, 1022),
                  $urandom_range(1, 1023), 180};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                settle();
                write_span(spans[p]);
            end
            span_now = spans[p];
            // One phase runs with no gaps or stalls at all.
            src_gaps = (p != 2);
            sink_stalls = (p != 2);

            // Directed levels for the interesting ranges.
            case (p)
                0: begin
                    send_level(0);             // exactly 0 dB
                    send_level(131071);        // largest positive level
                    send_level(256);           // +1 dB
                    send_level(-1);            // smallest negative step
                    send_level(-131072);       // most negative level
                    send_level(-46080);        // exactly on the floor
                    send_level(-46079);        // just above the floor
                    send_level(-2560);         // exactly on the second entry
                    send_level(-1280);         // half way between the first two entries
                    send_level(-1281);
                    send_level(-23040);        // middle of the palette
                end
                1: begin
                    send_level(-1);
                    send_level(-14);
                    send_level(-15);
                    send_level(-255);          // last entry pair, large fraction
                    send_level(-256);          // floor with the smallest range
                    send_level(-257);
                    send_level(1);
                end
                2: begin
                    send_level(-131072);
                    send_level(-131071);
                    send_level(-1);
                    send_level(0);
                end
                3: begin
                    // A zero range behaves like a range of one.
                    send_level(-1);
                    send_level(-256);
                    send_level(-255);
                    send_level(-15);
                end
                default: begin
                end
            endcase

            repeat (160) send_level(random_level(span_now));
            s_tvalid <= 1'b0;
        end

        @(posedge aclk);
        while (pixels_due != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0 && pixels_due == 0) begin
            $display("db_to_heat_colour_map_unit verification clean");
        end else begin
            $display("db_to_heat_colour_map_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dthc_pkg.sv
rtl/dthc_div_stage.sv
rtl/db_to_heat_colour_map_unit.sv
rtl/dthc_checker.sv
verif/heat_pixel_checker.sv
verif/tb_db_to_heat_colour_map_unit.sv
